// File: hw/rtl/sma_crossover_signal_macros.svh
// ----------------------------------------------------------------------------
// sma crossover signal assertion macros
// shared property shapes for the checker, clocked on clk, quiet in reset
// ----------------------------------------------------------------------------
`ifndef SMA_CROSSOVER_SIGNAL_MACROS_SVH
`define SMA_CROSSOVER_SIGNAL_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define SMACS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define SMACS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/smacs_pkg.sv
// ----------------------------------------------------------------------------
// smacs_pkg
// shared types and constants of the moving average crossover block
// ----------------------------------------------------------------------------
package smacs_pkg;

  // fixed field widths
  localparam int PRICE_W   = 32;
  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 2;
  localparam int SIG_W     = 2;
  localparam int COUNT_W   = 9;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // parameter defaults
  localparam int DEF_WINDOW_DEPTH = 256;
  localparam int DEF_PRICE_BITS   = 32;

  // period reset values
  localparam logic [CFG_W-1:0] SHORT_RESET = CFG_W'(20);
  localparam logic [CFG_W-1:0] LONG_RESET  = CFG_W'(50);

  typedef enum logic [1:0] {
    REL_LESS    = 2'd0,
    REL_EQUAL   = 2'd1,
    REL_GREATER = 2'd2
  } rel_t;

  typedef enum logic [SIG_W-1:0] {
    SIG_NONE = 2'd0,
    SIG_BUY  = 2'd1,
    SIG_SELL = 2'd2
  } sig_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SHORT = 2'd0,
    CFG_LONG  = 2'd1
  } cfg_idx_t;

  // control of the cell row
  typedef struct packed {
    logic shift;   // advance every cell by one place
    logic rotate;  // feed the oldest history entry back into cell 0
  } row_ctl_t;

  // load strobes of the compare pipeline
  typedef struct packed {
    logic m_load;  // products register takes the current sums
    logic o_load;  // output register takes the decision
  } cross_ctl_t;

endpackage

// File: hw/rtl/smacs_cell.sv
// ----------------------------------------------------------------------------
// smacs_cell
// one place of the price row: history entry plus short and long exit lines
// ----------------------------------------------------------------------------
module smacs_cell
  import smacs_pkg::*;
#(
  parameter int DEPTH = DEF_WINDOW_DEPTH,
  parameter int DW    = DEF_PRICE_BITS,
  parameter int PER_W = 9,
  parameter int IDX   = 0
) (
  input  logic             clk,
  input  logic             shift,
  input  logic [DW-1:0]    h_prev,
  input  logic [DW-1:0]    ds_prev,
  input  logic [DW-1:0]    dl_prev,
  input  logic [DW-1:0]    inj_val,
  input  logic [PER_W-1:0] sp,
  input  logic [PER_W-1:0] lp,
  output logic [DW-1:0]    h,
  output logic [DW-1:0]    ds,
  output logic [DW-1:0]    dl
);

  // a window of n items enters its exit line n places before the end
  localparam logic [PER_W-1:0] INJ_AT = PER_W'(DEPTH - IDX);

  logic [DW-1:0] h_r;
  logic [DW-1:0] ds_r;
  logic [DW-1:0] dl_r;
  logic          inj_s;
  logic          inj_l;

  assign inj_s = (sp == INJ_AT);
  assign inj_l = (lp == INJ_AT);

  always_ff @(posedge clk) begin
    if (shift) begin
      h_r  <= h_prev;
      ds_r <= inj_s ? inj_val : ds_prev;
      dl_r <= inj_l ? inj_val : dl_prev;
    end
  end

  assign h  = h_r;
  assign ds = ds_r;
  assign dl = dl_r;

endmodule

// File: hw/rtl/smacs_row.sv
// ----------------------------------------------------------------------------
// smacs_row
// row of price cells, newest at cell 0, exits at the far end
// ----------------------------------------------------------------------------
module smacs_row
  import smacs_pkg::*;
#(
  parameter int DEPTH = DEF_WINDOW_DEPTH,
  parameter int DW    = DEF_PRICE_BITS,
  parameter int PER_W = 9
) (
  input  logic             clk,
  input  row_ctl_t         ctl,
  input  logic [DW-1:0]    price,
  input  logic [DW-1:0]    inj_val,
  input  logic [PER_W-1:0] sp,
  input  logic [PER_W-1:0] lp,
  output logic [DW-1:0]    h_tail,
  output logic [DW-1:0]    ds_tail,
  output logic [DW-1:0]    dl_tail
);

  logic [DW-1:0] h_w      [DEPTH];
  logic [DW-1:0] ds_w     [DEPTH];
  logic [DW-1:0] dl_w     [DEPTH];
  logic [DW-1:0] h_prev_w [DEPTH];
  logic [DW-1:0] ds_prev_w[DEPTH];
  logic [DW-1:0] dl_prev_w[DEPTH];

  // cell 0 takes the new price, or the oldest entry while the row rotates
  assign h_prev_w[0]  = ctl.rotate ? h_w[DEPTH-1] : price;
  assign ds_prev_w[0] = inj_val;
  assign dl_prev_w[0] = inj_val;

  genvar i;
  generate
    for (i = 1; i < DEPTH; i++) begin : g_link
      assign h_prev_w[i]  = h_w[i-1];
      assign ds_prev_w[i] = ds_w[i-1];
      assign dl_prev_w[i] = dl_w[i-1];
    end

    for (i = 0; i < DEPTH; i++) begin : g_cell
      smacs_cell #(
        .DEPTH (DEPTH),
        .DW    (DW),
        .PER_W (PER_W),
        .IDX   (i)
      ) u_cell (
        .clk     (clk),
        .shift   (ctl.shift),
        .h_prev  (h_prev_w[i]),
        .ds_prev (ds_prev_w[i]),
        .dl_prev (dl_prev_w[i]),
        .inj_val (inj_val),
        .sp      (sp),
        .lp      (lp),
        .h       (h_w[i]),
        .ds      (ds_w[i]),
        .dl      (dl_w[i])
      );
    end
  endgenerate

  assign h_tail  = h_w[DEPTH-1];
  assign ds_tail = ds_w[DEPTH-1];
  assign dl_tail = dl_w[DEPTH-1];

endmodule

// File: hw/rtl/smacs_cross.sv
// ----------------------------------------------------------------------------
// smacs_cross
// cross-multiply stage, exact compare and crossover decision
// ----------------------------------------------------------------------------
module smacs_cross
  import smacs_pkg::*;
#(
  parameter int SUM_W = 40,
  parameter int PER_W = 9
) (
  input  logic             clk,
  input  logic             rst_n,
  input  cross_ctl_t       ctl,
  input  logic [SUM_W-1:0] sum_s,
  input  logic [SUM_W-1:0] sum_l,
  input  logic [PER_W-1:0] sp,
  input  logic [PER_W-1:0] lp,
  input  logic             armed_in,
  output logic [SIG_W-1:0] sig_o,
  output logic             armed_o
);

  localparam int PROD_W = SUM_W + PER_W;

  logic [PROD_W-1:0] prod_s_r;
  logic [PROD_W-1:0] prod_l_r;
  logic [PROD_W-1:0] prod_s_nxt;
  logic [PROD_W-1:0] prod_l_nxt;
  logic              m_armed_r;
  rel_t              rel;
  rel_t              last_rel_r;
  sig_t              sig_nxt;
  sig_t              sig_r;
  logic              armed_r;

  // short average above long average <=> short_sum*lp > long_sum*sp
  assign prod_s_nxt = PROD_W'(sum_s) * PROD_W'(lp);
  assign prod_l_nxt = PROD_W'(sum_l) * PROD_W'(sp);

  always_ff @(posedge clk) begin
    if (ctl.m_load) begin
      prod_s_r  <= prod_s_nxt;
      prod_l_r  <= prod_l_nxt;
      m_armed_r <= armed_in;
    end
  end

  always_comb begin
    if (prod_s_r > prod_l_r) begin
      rel = REL_GREATER;
    end else if (prod_s_r < prod_l_r) begin
      rel = REL_LESS;
    end else begin
      rel = REL_EQUAL;
    end
  end

  always_comb begin
    sig_nxt = SIG_NONE;
    if (m_armed_r) begin
      case (rel)
        REL_GREATER: begin
          if (last_rel_r != REL_GREATER) sig_nxt = SIG_BUY;
        end
        REL_LESS: begin
          if (last_rel_r != REL_LESS) sig_nxt = SIG_SELL;
        end
        default: begin
          sig_nxt = SIG_NONE;
        end
      endcase
    end
  end

  // relation is kept on every item, armed or not
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_rel_r <= REL_EQUAL;
    end else if (ctl.o_load) begin
      last_rel_r <= rel;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.o_load) begin
      sig_r   <= sig_nxt;
      armed_r <= m_armed_r;
    end
  end

  assign sig_o   = sig_r;
  assign armed_o = armed_r;

endmodule

// File: hw/rtl/sma_crossover_signal.sv
// ----------------------------------------------------------------------------
// sma_crossover_signal
// moving average crossover signal over a stream of mid prices
// ----------------------------------------------------------------------------
// One price item is taken per clock while in_stall is low and gives exactly
// one result item (signal, armed); items stream back to back, and a stalled
// result leaves room for two more items inside before in_stall rises.
// The price history lives in a row of WINDOW_DEPTH cells that shift by one
// place per item; two exit lines in the same cells hand over the price that
// leaves the short and the long window, so both sums are kept by one add and
// one subtract per item. The averages are compared exactly by
// cross-multiplying (short_sum*long_period vs long_sum*short_period) in a
// registered multiply stage. After reset and after every configuration write
// the block rebuilds its sums and exit lines from the history: it rotates the
// row once around, which holds in_stall high for the whole pass (a write
// during a rebuild queues one more full pass). A period of 0 acts as 1 and a
// period above WINDOW_DEPTH acts as WINDOW_DEPTH.
// ----------------------------------------------------------------------------
module sma_crossover_signal
  import smacs_pkg::*;
#(
  parameter int WINDOW_DEPTH = DEF_WINDOW_DEPTH,
  parameter int PRICE_BITS   = DEF_PRICE_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // price items
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [PRICE_W-1:0]   in_price,
  // result items
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [SIG_W-1:0]     out_signal,
  output logic                 out_armed,
  // configuration writes
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  // used price bits, history index, period and sum widths
  localparam int HIST_W = (PRICE_BITS < PRICE_W) ? PRICE_BITS : PRICE_W;
  localparam int IDX_W  = $clog2(WINDOW_DEPTH);
  localparam int PER_W  = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W  = HIST_W + IDX_W;
  localparam int CMP_W  = (CFG_W > PER_W) ? CFG_W : PER_W;
  localparam int NEED_W = (COUNT_W > PER_W) ? COUNT_W : PER_W;
  localparam int KC_W   = (COUNT_W > IDX_W) ? COUNT_W : IDX_W;

  localparam logic [IDX_W-1:0] K_LAST = IDX_W'(WINDOW_DEPTH - 1);

  // effective period: zero acts as one, clipped to the row length
  function automatic logic [PER_W-1:0] eff_period(input logic [CFG_W-1:0] p);
    logic [CMP_W-1:0] pe;
    pe = CMP_W'(p);
    if (pe == '0) begin
      eff_period = PER_W'(1);
    end else if (pe > CMP_W'(WINDOW_DEPTH)) begin
      eff_period = PER_W'(WINDOW_DEPTH);
    end else begin
      eff_period = PER_W'(pe);
    end
  endfunction

  // configuration
  logic [CFG_W-1:0]   short_r;
  logic [CFG_W-1:0]   long_r;
  logic [PER_W-1:0]   sp;
  logic [PER_W-1:0]   lp;
  logic [PER_W-1:0]   need;

  // handshake and pipeline occupancy
  logic               acc;
  logic               a_vld_r;
  logic               m_vld_r;
  logic               out_vld_r;
  logic               a_ready;
  logic               m_ready;
  logic               o_ready;
  logic               a_armed_r;
  logic               armed_nxt;

  // sample count and running sums
  logic [COUNT_W-1:0] count_r;
  logic [COUNT_W-1:0] count_nxt;
  logic [SUM_W-1:0]   sum_s_r;
  logic [SUM_W-1:0]   sum_l_r;
  logic [SUM_W-1:0]   sum_s_nxt;
  logic [SUM_W-1:0]   sum_l_nxt;

  // rebuild sweep
  logic               rb_busy_r;
  logic               rb_busy_nxt;
  logic               rb_pend_r;
  logic               rb_pend_nxt;
  logic [IDX_W-1:0]   rb_k_r;
  logic [IDX_W-1:0]   rb_k_nxt;
  logic [HIST_W-1:0]  rb_val;

  // row interface
  logic [HIST_W-1:0]  price_m;
  logic [HIST_W-1:0]  inj_val;
  logic [HIST_W-1:0]  h_tail;
  logic [HIST_W-1:0]  ds_tail;
  logic [HIST_W-1:0]  dl_tail;
  row_ctl_t           row_ctl;
  cross_ctl_t         cross_ctl;

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      short_r <= SHORT_RESET;
      long_r  <= LONG_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SHORT: short_r <= cfg_wdata;
        CFG_LONG:  long_r  <= cfg_wdata;
        default: begin
          short_r <= short_r;
        end
      endcase
    end
  end

  assign sp   = eff_period(short_r);
  assign lp   = eff_period(long_r);
  assign need = (sp > lp) ? sp : lp;

  // ---------------------------------------------------------------------------
  // handshake: three slots (sums, products, output) each with its own valid
  // ---------------------------------------------------------------------------
  assign o_ready  = !out_vld_r || !out_stall;
  assign m_ready  = !m_vld_r || o_ready;
  assign a_ready  = !a_vld_r || m_ready;
  assign in_stall = rb_busy_r || !a_ready;
  assign acc      = in_valid && !in_stall;

  assign cross_ctl.m_load = a_vld_r && m_ready;
  assign cross_ctl.o_load = m_vld_r && o_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r   <= 1'b0;
      m_vld_r   <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      a_vld_r   <= acc || (a_vld_r && !m_ready);
      m_vld_r   <= cross_ctl.m_load || (m_vld_r && !o_ready);
      out_vld_r <= cross_ctl.o_load || (out_vld_r && out_stall);
    end
  end

  assign out_valid = out_vld_r;

  // ---------------------------------------------------------------------------
  // sample count and armed flag, worked out as the item enters
  // ---------------------------------------------------------------------------
  assign count_nxt = (count_r == COUNT_MAX) ? count_r : count_r + COUNT_W'(1);
  assign armed_nxt = (NEED_W'(count_nxt) >= NEED_W'(need)) &&
                     (count_nxt >= COUNT_W'(2));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (acc) begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      a_armed_r <= armed_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // running sums and rebuild sweep
  // during a sweep the row rotates, the oldest entry comes out first, and
  // entries that were never written (index at or past the count) read as zero
  // ---------------------------------------------------------------------------
  assign price_m = in_price[HIST_W-1:0];
  assign rb_val  = (KC_W'(rb_k_r) < KC_W'(count_r)) ? h_tail : '0;
  assign inj_val = rb_busy_r ? rb_val : price_m;

  always_comb begin
    rb_busy_nxt = rb_busy_r;
    rb_pend_nxt = rb_pend_r;
    rb_k_nxt    = rb_k_r;
    sum_s_nxt   = sum_s_r;
    sum_l_nxt   = sum_l_r;
    if (rb_busy_r) begin
      sum_s_nxt = sum_s_r + ((PER_W'(rb_k_r) < sp) ? SUM_W'(rb_val) : '0);
      sum_l_nxt = sum_l_r + ((PER_W'(rb_k_r) < lp) ? SUM_W'(rb_val) : '0);
      if (rb_k_r == '0) begin
        // last step of the pass; a queued write starts a fresh one
        if (cfg_we || rb_pend_r) begin
          rb_k_nxt    = K_LAST;
          rb_pend_nxt = 1'b0;
          sum_s_nxt   = '0;
          sum_l_nxt   = '0;
        end else begin
          rb_busy_nxt = 1'b0;
        end
      end else begin
        rb_k_nxt    = rb_k_r - IDX_W'(1);
        rb_pend_nxt = rb_pend_r || cfg_we;
      end
    end else if (cfg_we) begin
      rb_busy_nxt = 1'b1;
      rb_k_nxt    = K_LAST;
      sum_s_nxt   = '0;
      sum_l_nxt   = '0;
    end else if (acc) begin
      // new price enters both windows, the exit lines give what leaves
      sum_s_nxt = sum_s_r + SUM_W'(price_m) - SUM_W'(ds_tail);
      sum_l_nxt = sum_l_r + SUM_W'(price_m) - SUM_W'(dl_tail);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rb_busy_r <= 1'b1;
      rb_pend_r <= 1'b0;
      rb_k_r    <= K_LAST;
      sum_s_r   <= '0;
      sum_l_r   <= '0;
    end else begin
      rb_busy_r <= rb_busy_nxt;
      rb_pend_r <= rb_pend_nxt;
      rb_k_r    <= rb_k_nxt;
      sum_s_r   <= sum_s_nxt;
      sum_l_r   <= sum_l_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // price row
  // ---------------------------------------------------------------------------
  assign row_ctl.shift  = acc || rb_busy_r;
  assign row_ctl.rotate = rb_busy_r;

  smacs_row #(
    .DEPTH (WINDOW_DEPTH),
    .DW    (HIST_W),
    .PER_W (PER_W)
  ) u_row (
    .clk     (clk),
    .ctl     (row_ctl),
    .price   (price_m),
    .inj_val (inj_val),
    .sp      (sp),
    .lp      (lp),
    .h_tail  (h_tail),
    .ds_tail (ds_tail),
    .dl_tail (dl_tail)
  );

  // ---------------------------------------------------------------------------
  // cross-multiply, compare and decision
  // ---------------------------------------------------------------------------
  smacs_cross #(
    .SUM_W (SUM_W),
    .PER_W (PER_W)
  ) u_cross (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (cross_ctl),
    .sum_s    (sum_s_r),
    .sum_l    (sum_l_r),
    .sp       (sp),
    .lp       (lp),
    .armed_in (a_armed_r),
    .sig_o    (out_signal),
    .armed_o  (out_armed)
  );

endmodule

// File: hw/rtl/smacs_checker.sv
// ----------------------------------------------------------------------------
// smacs_checker
// port-level checks of the crossover block, bound to the top level
// ----------------------------------------------------------------------------
`include "sma_crossover_signal_macros.svh"

module smacs_checker
  import smacs_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic [SIG_W-1:0]     out_signal,
  input logic                 out_armed,
  input logic                 cfg_we
);

  // a trade signal only ever comes from an armed item
  `SMACS_ASSERT_SAME(a_sig_needs_armed, out_valid && out_signal != SIG_NONE, out_armed, "signal while not armed")

  // a held result keeps its payload
  `SMACS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_signal) && $stable(out_armed), "stalled result changed")

  // a period write starts a rebuild that blocks new items
  `SMACS_ASSERT_NEXT(a_cfg_rebuild, cfg_we, in_stall, "item taken during rebuild after write")

  // the rebuild after reset blocks new items
  `SMACS_ASSERT_SAME(a_reset_rebuild, $past(!rst_n), in_stall, "item taken right after reset")

endmodule

bind sma_crossover_signal smacs_checker u_smacs_checker (.*);

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// stream test of the moving average crossover block: a scoreboard predicts
// signal and armed for every accepted price item from its own copy of the
// price history and the period registers, and checks each result item in order
// ----------------------------------------------------------------------------
module tb_top;
  import smacs_pkg::*;

  localparam int HIST_DEPTH     = DEF_WINDOW_DEPTH;
  localparam int RANDOM_ITEMS   = 1750;
  localparam int TIMEOUT_CYCLES = 800000;
  localparam int PRINT_CAP      = 50;

  // config indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  typedef struct packed {
    sig_t signal;
    logic armed;
  } crossover_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [PRICE_W-1:0]   in_price;
  logic                 out_valid;
  logic                 out_stall;
  logic [SIG_W-1:0]     out_signal;
  logic                 out_armed;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  // scoreboard copy of the block state
  logic [PRICE_W-1:0]   hist_mem [HIST_DEPTH];
  logic [7:0]           hist_wr_ptr;
  logic [COUNT_W-1:0]   sample_cnt;
  rel_t                 prev_rel;
  logic [CFG_W-1:0]     short_len_reg;
  logic [CFG_W-1:0]     long_len_reg;
  crossover_t           pending_results [$];

  int mismatch_count = 0;
  int hold_req       = 0;   // receiver hold-off request, taken by the stall process
  bit gaps_off       = 1'b0;  // when set, sender offers items back to back

  sma_crossover_signal u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_price   (in_price),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_signal (out_signal),
    .out_armed  (out_armed),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // ---------------------------------------------------------------------------
  // scoreboard
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatch_count < PRINT_CAP)
      $display("mismatch on %s: got %0d expected %0d at %0t", what, got, want, $time);
    mismatch_count++;
  endtask

  // period register as the block uses it: zero acts as one, clipped to the ring
  function automatic int eff_len(input logic [CFG_W-1:0] p);
    if (p == '0) return 1;
    if (int'(p) > HIST_DEPTH) return HIST_DEPTH;
    return int'(p);
  endfunction

  // put one price into the history and work out the crossover result
  task automatic predict_crossover(input logic [PRICE_W-1:0] price);
    int          sp;
    int          lp;
    int          need;
    logic [63:0] short_total;
    logic [63:0] long_total;
    logic [63:0] lhs;
    logic [63:0] rhs;
    rel_t        rel;
    crossover_t  res;
    sp = eff_len(short_len_reg);
    lp = eff_len(long_len_reg);
    need = (sp > lp) ? sp : lp;
    hist_mem[hist_wr_ptr] = price;
    hist_wr_ptr = hist_wr_ptr + 8'd1;
    if (sample_cnt != COUNT_MAX) sample_cnt = sample_cnt + 1'b1;
    // both sums formed afresh from the ring, newest entry just below the pointer
    short_total = '0;
    long_total = '0;
    for (int k = 0; k < sp; k++) short_total += 64'(hist_mem[8'(hist_wr_ptr - 1 - k)]);
    for (int k = 0; k < lp; k++) long_total += 64'(hist_mem[8'(hist_wr_ptr - 1 - k)]);
    // exact compare of the averages by cross-multiplying
    lhs = short_total * 64'(lp);
    rhs = long_total * 64'(sp);
    if (lhs > rhs) rel = REL_GREATER;
    else if (lhs < rhs) rel = REL_LESS;
    else rel = REL_EQUAL;
    res.signal = SIG_NONE;
    res.armed = (int'(sample_cnt) >= need) && (sample_cnt >= 2);
    if (res.armed) begin
      if (rel == REL_GREATER && prev_rel != REL_GREATER) res.signal = SIG_BUY;
      else if (rel == REL_LESS && prev_rel != REL_LESS) res.signal = SIG_SELL;
    end
    prev_rel = rel;
    pending_results = {pending_results, res};
  endtask

  initial begin
    for (int i = 0; i < HIST_DEPTH; i++) hist_mem[i] = '0;
    hist_wr_ptr = '0;
    sample_cnt = '0;
    prev_rel = REL_EQUAL;
    short_len_reg = SHORT_RESET;
    long_len_reg = LONG_RESET;
  end

  // results are checked before the item of the same edge is predicted, so the
  // outcome never hangs on process order
  always @(posedge clk) begin : monitor
    crossover_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result with nothing pending", int'(out_signal), 0);
        end else begin
          want = pending_results.pop_front();
          if (out_signal !== want.signal)
            report_mismatch("signal", int'(out_signal), int'(want.signal));
          if (out_armed !== want.armed)
            report_mismatch("armed", int'(out_armed), int'(want.armed));
        end
      end
      if (in_valid && !in_stall) predict_crossover(in_price);
      if (cfg_we) begin
        case (cfg_index)
          CFG_SHORT: short_len_reg = cfg_wdata;
          CFG_LONG:  long_len_reg = cfg_wdata;
          default: ;  // spare index, no register
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: random stall runs, long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin : result_stall
    int run_left;
    int hold_left;
    int r;
    bit run_stall;
    out_stall = 1'b0;
    run_left = 0;
    hold_left = 0;
    run_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        if (run_left == 0) begin
          r = $urandom_range(0, 99);
          if (r < 45) begin
            run_stall = 1'b0;
            run_left = $urandom_range(1, 8);
          end else if (r < 70) begin
            // a stretch with no stall at all
            run_stall = 1'b0;
            run_left = $urandom_range(20, 80);
          end else if (r < 92) begin
            run_stall = 1'b1;
            run_left = $urandom_range(1, 3);
          end else begin
            run_stall = 1'b1;
            run_left = $urandom_range(8, 40);
          end
        end
        out_stall <= run_stall;
        run_left--;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sender side
  // ---------------------------------------------------------------------------

  function automatic int pick_gap();
    int r;
    if (gaps_off) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 96) return $urandom_range(3, 6);
    return $urandom_range(10, 40);
  endfunction

  // offer one price item and hold it until the block takes it
  task automatic offer_price(input logic [PRICE_W-1:0] price);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_price <= price;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // stop offering, wait for every pending result, then let the pipe settle
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // only called with nothing in flight
  task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [CFG_W-1:0] pick_period();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return CFG_W'($urandom_range(1, 12));
    if (r < 75) return CFG_W'($urandom_range(13, 64));
    if (r < 83) return '0;
    if (r < 88) return CFG_W'(HIST_DEPTH);
    if (r < 93) return '1;
    return CFG_W'($urandom_range(65, 300));
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // both windows one sample wide: must stay unarmed until the second sample
  task automatic test_single_sample_windows();
    write_reg(CFG_SHORT, CFG_W'(1));
    write_reg(CFG_LONG, CFG_W'(1));
    offer_price(32'd100);
    offer_price(32'd200);
    offer_price(32'd50);
    drain_results();
  endtask

  // short window of one against two: a rise is a buy and a fall a sell, unless the item before moved the same way
  task automatic test_extreme_prices();
    write_reg(CFG_SHORT, CFG_W'(1));
    write_reg(CFG_LONG, CFG_W'(2));
    offer_price(32'h0000_0000);
    offer_price(32'hFFFF_FFFF);
    offer_price(32'hFFFF_FFFF);
    offer_price(32'h0000_0000);
    offer_price(32'h0000_0000);
    offer_price(32'hFFFF_FFFF);
    offer_price(32'h8000_0000);
    offer_price(32'h7FFF_FFFF);
    drain_results();
  endtask

  // a zero short period acts as one
  task automatic test_zero_period();
    write_reg(CFG_SHORT, '0);
    write_reg(CFG_LONG, CFG_W'(3));
    offer_price(32'd10);
    offer_price(32'd20);
    offer_price(32'd5);
    offer_price(32'd30);
    drain_results();
  endtask

  // periods past the ring depth clip to the full ring
  task automatic test_period_beyond_depth();
    write_reg(CFG_SHORT, '1);
    write_reg(CFG_LONG, CFG_W'(257));
    offer_price(32'hFFFF_FFFF);
    offer_price(32'hFFFF_FFFE);
    offer_price(32'd1);
    drain_results();
  endtask

  // spare indexes must leave both periods alone
  task automatic test_spare_index();
    write_reg(CFG_SHORT, CFG_W'(2));
    write_reg(CFG_LONG, CFG_W'(4));
    write_reg(CFG_SPARE_A, '1);
    write_reg(CFG_SPARE_B, CFG_W'(3));
    offer_price(32'd7000);
    offer_price(32'd9000);
    offer_price(32'd1000);
    drain_results();
  endtask

  // new periods on a live history, long one zero, last relation carried over
  task automatic test_period_change();
    write_reg(CFG_SHORT, CFG_W'(3));
    write_reg(CFG_LONG, '0);
    offer_price(32'd400);
    offer_price(32'd300);
    offer_price(32'd500);
    drain_results();
  endtask

  // receiver holds off long while items keep coming, so the block fills up
  task automatic test_backpressure();
    write_reg(CFG_SHORT, CFG_W'(4));
    write_reg(CFG_LONG, CFG_W'(9));
    gaps_off = 1'b1;
    offer_price(32'd5000);
    hold_req = 400;
    for (int i = 0; i < 40; i++) offer_price(32'($urandom_range(4000, 6000)));
    gaps_off = 1'b0;
    drain_results();
  endtask

  // phases of random walks with turns, so the averages cross often, with
  // random period settings between phases and some plain noise items
  task automatic test_random_streams();
    int                 sent;
    int                 len;
    int                 style;
    int                 pick;
    int                 step_max;
    int                 dir;
    longint             cur;
    logic [PRICE_W-1:0] price;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      drain_results();
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        write_reg(CFG_SHORT, pick_period());
        write_reg(CFG_LONG, pick_period());
      end else if (pick == 6) begin
        write_reg(CFG_SHORT, pick_period());
      end else if (pick == 7) begin
        write_reg(CFG_LONG, pick_period());
      end else if (pick == 8) begin
        write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B, CFG_W'($urandom));
      end
      gaps_off = ($urandom_range(0, 4) == 0);
      style = $urandom_range(0, 9);
      len = $urandom_range(20, 80);
      step_max = 1 << $urandom_range(0, 24);
      dir = $urandom_range(0, 1) ? 1 : -1;
      case (style)
        0: cur = longint'($urandom_range(0, 1000));         // near zero
        1: cur = 64'sd4294967295 - $urandom_range(0, 1000); // near the top
        2: step_max = 0;                                     // flat with noise
        default: cur = longint'($urandom);
      endcase
      if (style == 2) cur = longint'($urandom);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 7) == 0) dir = -dir;
        cur += longint'($urandom_range(0, step_max)) * dir;
        if (cur < 0) cur = 0;
        if (cur > 64'sd4294967295) cur = 64'sd4294967295;
        // style 9 is pure noise, the rest carry a noise item now and then
        if (style == 9 || $urandom_range(0, 11) == 0) price = $urandom;
        else price = cur[31:0];
        offer_price(price);
        sent++;
      end
    end
    gaps_off = 1'b0;
    drain_results();
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_price = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    // single sample windows first, the sample count never clears again
    test_single_sample_windows();
    test_extreme_prices();
    test_zero_period();
    test_period_beyond_depth();
    test_spare_index();
    test_period_change();
    test_backpressure();
    test_random_streams();
    drain_results();
    repeat (8) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // hard stop if the block hangs or drops results
  initial begin
    repeat (TIMEOUT_CYCLES) @(posedge clk);
    $display("Simulation FAILED");
    $finish;
  end

endmodule
